// ===== design/cpht_pkg.sv =====
// Shared types and constants for the convex polygon hit test.
// Used by cpht_ctrl, cpht_dp and convex_polygon_hit_test; depends on nothing.
package cpht_pkg;

  localparam int CFG_IDX_W    = 3;
  localparam int CNT_FIELD_W  = 4;
  localparam int MIN_VERTICES = 3;

  // input opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LEFT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_TOP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic wr_en;   // store a vertex beat
    logic load;    // latch query point and box test
    logic rd_en;   // read one vertex
    logic first;   // the read is vertex 0
    logic close;   // closing edge back to vertex 0
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fin;     // last edge evaluated, result shown this cycle
  } sts_t;

endpackage

// ===== design/cpht_ctrl.sv =====
// Controller for the convex polygon hit test: accepts beats, sequences vertex reads.
// Depends on cpht_pkg.
module cpht_ctrl #(
  parameter int MAX_VERTICES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                opcode,
  input  logic [cpht_pkg::CNT_FIELD_W-1:0]    vertex_count,
  input  cpht_pkg::sts_t                      sts,
  output cpht_pkg::cmd_t                      cmd,
  output logic [$clog2(MAX_VERTICES)-1:0]     rd_addr,
  output logic                                busy
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  cpht_pkg::state_t   state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   n_act;

  // clamp the vertex count into the usable range
  always_comb begin
    if (32'(vertex_count) < 32'(cpht_pkg::MIN_VERTICES)) begin
      n_act = CNT_W'(cpht_pkg::MIN_VERTICES);
    end else if (32'(vertex_count) > 32'(MAX_VERTICES)) begin
      n_act = CNT_W'(MAX_VERTICES);
    end else begin
      n_act = CNT_W'(vertex_count);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    cmd       = '0;
    case (state_r)
      cpht_pkg::ST_IDLE: begin
        if (start) begin
          if (opcode == cpht_pkg::OP_QUERY) begin
            cmd.load  = 1'b1;
            cnt_nxt   = '0;
            n_nxt     = n_act;
            state_nxt = cpht_pkg::ST_WALK;
          end else begin
            cmd.wr_en = 1'b1;
          end
        end
      end
      cpht_pkg::ST_WALK: begin
        if (cnt_r == n_r) begin
          cmd.close = 1'b1;
          state_nxt = cpht_pkg::ST_WAIT;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.first = (cnt_r == '0);
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      cpht_pkg::ST_WAIT: begin
        if (sts.fin) begin
          state_nxt = cpht_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cpht_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cpht_pkg::ST_IDLE;
      cnt_r   <= '0;
      n_r     <= CNT_W'(cpht_pkg::MIN_VERTICES);
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
    end
  end

  assign rd_addr = cnt_r[IDX_W-1:0];
  assign busy    = (state_r != cpht_pkg::ST_IDLE);

endmodule

// ===== design/cpht_dp.sv =====
// Datapath for the convex polygon hit test: vertex memory, box test,
// edge/cross-product pipeline and sign tracking. Depends on cpht_pkg.
module cpht_dp #(
  parameter int MAX_VERTICES = 8,
  parameter int COORD_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cpht_pkg::cmd_t                      cmd,
  input  logic [$clog2(MAX_VERTICES)-1:0]     rd_addr,
  input  logic [2:0]                          vertex_index,
  input  logic signed [COORD_BITS-1:0]        coord_x,
  input  logic signed [COORD_BITS-1:0]        coord_y,
  input  logic signed [COORD_BITS-1:0]        box_left,
  input  logic signed [COORD_BITS-1:0]        box_top,
  input  logic [COORD_BITS-1:0]               box_width,
  input  logic [COORD_BITS-1:0]               box_height,
  output cpht_pkg::sts_t                      sts,
  output logic                                inside_res
);

  localparam int C     = COORD_BITS;
  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int D     = C + 1;       // coordinate difference
  localparam int P     = 2 * D;       // product
  localparam int X     = P + 1;       // cross product
  localparam int B     = C + 2;       // box edge sums

  logic [2*C-1:0] mem [MAX_VERTICES];
  logic [2*C-1:0] rdata_r;

  logic [31:0]      wr_idx;
  logic             wr_ok;
  logic [IDX_W-1:0] wr_addr;

  assign wr_idx  = 32'(vertex_index);
  assign wr_ok   = wr_idx < 32'(MAX_VERTICES);
  assign wr_addr = wr_idx[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_ok) begin
      mem[wr_addr] <= {coord_x, coord_y};
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // bounding box test on the incoming query point, strict on all sides
  logic signed [B-1:0] px_ext, py_ext, right_ext, bottom_ext;
  logic                box_ok;

  assign px_ext     = {{2{coord_x[C-1]}}, coord_x};
  assign py_ext     = {{2{coord_y[C-1]}}, coord_y};
  assign right_ext  = {{2{box_left[C-1]}}, box_left} + $signed({2'b00, box_width});
  assign bottom_ext = {{2{box_top[C-1]}}, box_top} + $signed({2'b00, box_height});
  assign box_ok     = (coord_x > box_left) && (px_ext < right_ext) &&
                      (coord_y > box_top)  && (py_ext < bottom_ext);

  logic signed [C-1:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r <= coord_x;
      py_r <= coord_y;
    end
  end

  // stage 1: form edge and point offsets
  logic                v1_r, first1_r, close1_r;
  logic signed [C-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic signed [C-1:0] b_x, b_y;
  logic signed [D-1:0] ex_r, ey_r, qx_r, qy_r;
  logic                v2_r, last2_r;

  assign b_x = close1_r ? first_x_r : $signed(rdata_r[2*C-1:C]);
  assign b_y = close1_r ? first_y_r : $signed(rdata_r[C-1:0]);

  always_ff @(posedge clk) begin
    if (v1_r) begin
      prev_x_r <= b_x;
      prev_y_r <= b_y;
      if (first1_r) begin
        first_x_r <= b_x;
        first_y_r <= b_y;
      end else begin
        ex_r <= D'(b_x) - D'(prev_x_r);
        ey_r <= D'(b_y) - D'(prev_y_r);
        qx_r <= D'(px_r) - D'(prev_x_r);
        qy_r <= D'(py_r) - D'(prev_y_r);
      end
    end
  end

  // stage 2: the two products
  logic signed [P-1:0] p1_r, p2_r;
  logic                v3_r, last3_r;

  always_ff @(posedge clk) begin
    if (v2_r) begin
      p1_r <= ex_r * qy_r;
      p2_r <= ey_r * qx_r;
    end
  end

  // stage 3: sign of the cross product against the first sign seen
  logic [X-1:0] cross_w;
  logic         cross_neg, cross_zero, side_bad;
  logic         have_side_r, neg_r, ok_r, fin_r, res_r;

  assign cross_w    = {p1_r[P-1], p1_r} - {p2_r[P-1], p2_r};
  assign cross_neg  = cross_w[X-1];
  assign cross_zero = (cross_w == '0);
  assign side_bad   = cross_zero || (have_side_r && (cross_neg != neg_r));

  always_ff @(posedge clk) begin
    if (v3_r && !have_side_r) begin
      neg_r <= cross_neg;
    end
    if (v3_r && last3_r) begin
      res_r <= ok_r && !side_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      first1_r    <= 1'b0;
      close1_r    <= 1'b0;
      v2_r        <= 1'b0;
      last2_r     <= 1'b0;
      v3_r        <= 1'b0;
      last3_r     <= 1'b0;
      have_side_r <= 1'b0;
      ok_r        <= 1'b0;
      fin_r       <= 1'b0;
    end else begin
      v1_r     <= cmd.rd_en || cmd.close;
      first1_r <= cmd.first;
      close1_r <= cmd.close;
      v2_r     <= v1_r && !first1_r;
      last2_r  <= close1_r;
      v3_r     <= v2_r;
      last3_r  <= last2_r;
      fin_r    <= v3_r && last3_r;
      if (cmd.load) begin
        ok_r        <= box_ok;
        have_side_r <= 1'b0;
      end else if (v3_r) begin
        have_side_r <= 1'b1;
        if (side_bad) begin
          ok_r <= 1'b0;
        end
      end
    end
  end

  assign sts.fin    = fin_r;
  assign inside_res = res_r;

endmodule

// ===== design/convex_polygon_hit_test.sv =====
// Point-in-convex-polygon hit test. A vertex write leaves the block idle; a
// query strobes out_valid once its n vertices (n = clamped vertex count) and
// the closing edge are evaluated, and the next beat is taken only after the strobe.
// The walk is paced by the single vertex read port, one vertex per cycle.
// rst_n is synchronous: vertex_count resets to 3, box registers to 0;
// the vertex memory holds garbage until written. Results cannot be stalled.
module convex_polygon_hit_test #(
  parameter int MAX_VERTICES = 8,
  parameter int COORD_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_opcode,
  input  logic [2:0]                          in_vertex_index,
  input  logic signed [COORD_BITS-1:0]        in_coord_x,
  input  logic signed [COORD_BITS-1:0]        in_coord_y,
  output logic                                out_valid,
  output logic                                out_inside_res,
  input  logic                                cfg_we,
  input  logic [cpht_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_BITS-1:0]               cfg_data
);

  localparam int IDX_W = $clog2(MAX_VERTICES);

  logic [cpht_pkg::CNT_FIELD_W-1:0] vertex_count_r;
  logic signed [COORD_BITS-1:0]     box_left_r, box_top_r;
  logic [COORD_BITS-1:0]            box_width_r, box_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= cpht_pkg::CNT_FIELD_W'(cpht_pkg::MIN_VERTICES);
      box_left_r     <= '0;
      box_top_r      <= '0;
      box_width_r    <= '0;
      box_height_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cpht_pkg::REG_VERTEX_COUNT: vertex_count_r <= cfg_data[cpht_pkg::CNT_FIELD_W-1:0];
        cpht_pkg::REG_BOX_LEFT:     box_left_r     <= cfg_data;
        cpht_pkg::REG_BOX_TOP:      box_top_r      <= cfg_data;
        cpht_pkg::REG_BOX_WIDTH:    box_width_r    <= cfg_data;
        cpht_pkg::REG_BOX_HEIGHT:   box_height_r   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  cpht_pkg::cmd_t   cmd;
  cpht_pkg::sts_t   sts;
  logic [IDX_W-1:0] rd_addr;

  cpht_ctrl #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .opcode       (in_opcode),
    .vertex_count (vertex_count_r),
    .sts          (sts),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .busy         (busy)
  );

  cpht_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .rd_addr      (rd_addr),
    .vertex_index (in_vertex_index),
    .coord_x      (in_coord_x),
    .coord_y      (in_coord_y),
    .box_left     (box_left_r),
    .box_top      (box_top_r),
    .box_width    (box_width_r),
    .box_height   (box_height_r),
    .sts          (sts),
    .inside_res   (out_inside_res)
  );

  assign out_valid = sts.fin;

`ifndef SYNTH
  // a result only appears while a query is in flight
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside a query");

  // each query gives a single-cycle strobe
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // a vertex write leaves the block ready for the next beat
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == cpht_pkg::OP_WRITE) |=> !busy)
    else $error("vertex write made the block busy");

  // a query occupies the block
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == cpht_pkg::OP_QUERY) |=> busy)
    else $error("query not taken");
`endif

endmodule
